FILE: hdl/sfr_pkg.sv
// shared constants and types for the sync/type/crc16 frame receiver
package sfr_pkg;

	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int TABLE_DEPTH     = 256;

	localparam logic [7:0]  SYNC_RESET = 8'hAA;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;

	// input operation codes
	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_TABLE = 1'b1;

	// result status codes
	localparam logic ST_GOOD = 1'b0;
	localparam logic ST_BAD  = 1'b1;

	typedef struct packed {
		logic       start;
		logic       init;
		logic [7:0] data;
	} crc_cmd_t;

	typedef struct packed {
		logic        busy;
		logic [15:0] crc;
	} crc_sts_t;

endpackage

FILE: hdl/sfr_ram.sv
// generic single write port ram with registered read
module sfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/sfr_crc_unit.sv
// bit-serial crc-16/ccitt-false update, one shift-xor step per cycle
module sfr_crc_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  sfr_pkg::crc_cmd_t cmd,
	output sfr_pkg::crc_sts_t sts
);

	logic [15:0] crc_q;
	logic [2:0]  cnt_q;
	logic        busy_q;
	logic [15:0] seed;

	assign seed = cmd.init ? sfr_pkg::CRC_INIT : crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= sfr_pkg::CRC_INIT;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (cmd.start) begin
			crc_q  <= seed ^ {cmd.data, 8'h00};
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			crc_q <= crc_q[15] ? ({crc_q[14:0], 1'b0} ^ sfr_pkg::CRC_POLY)
			                   : {crc_q[14:0], 1'b0};
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.crc  = crc_q;

endmodule

FILE: hdl/sync_type_crc16_frame_receiver_unit.sv
// frame receiver top level: sequencer, length table, payload store and result register
//
//  channel | signals                                          | role
//  --------+--------------------------------------------------+---------------------------
//  in      | in_valid in_ready operation rx_byte table_type    | line byte or table write
//          | table_length                                     |
//  out     | out_valid out_ready status frame_ver frame_type   | one word per payload byte,
//          | frame_length byte_index payload_byte last         | or one for an empty/bad
//          |                                                  | frame
//  cfg     | cfg_valid cfg_ready cfg_data                      | sync byte, always ready
//
// a version, type or payload byte is accepted, then runs through 8 steps of the shared
// bit-serial crc shift-xor unit, and the sequencer returns to idle once it sees the unit
// idle; sync, crc low byte and table writes do not wait on it. the crc high byte starts
// the drain, each word passing the payload ram read, then the result register. reset
// clears the 256 length-table valid bits at once. a full result register stalls only the
// drain; input is taken again once the last word of a frame sits in the result register.
module sync_type_crc16_frame_receiver_unit #(
	parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  logic [7:0] rx_byte,
	input  logic [7:0] table_type,
	input  logic [7:0] table_length,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       status,
	output logic [7:0] frame_ver,
	output logic [7:0] frame_type,
	output logic [5:0] frame_length,
	output logic [4:0] byte_index,
	output logic [7:0] payload_byte,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	// receive phase
	localparam logic [2:0] PH_SYNC    = 3'd0;
	localparam logic [2:0] PH_VERSION = 3'd1;
	localparam logic [2:0] PH_TYPE    = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_CRC_LO  = 3'd4;
	localparam logic [2:0] PH_CRC_HI  = 3'd5;

	// sequencer state
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CRC  = 2'd1;
	localparam logic [1:0] S_RD   = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]       state_q;
	logic [2:0]       phase_q;
	logic [7:0]       sync_q;
	logic [7:0]       version_q;
	logic [7:0]       type_q;
	logic [LEN_W-1:0] exp_len_q;
	logic [LEN_W-1:0] fill_q;
	logic [LEN_W-1:0] rd_idx_q;
	logic [7:0]       crc_lo_q;
	logic             lookup_q;
	logic             single_q;
	logic             err_q;
	logic [sfr_pkg::TABLE_DEPTH-1:0] tvalid_q;

	logic             out_valid_q;
	logic             status_q;
	logic [7:0]       version_out_q;
	logic [7:0]       type_out_q;
	logic [5:0]       length_out_q;
	logic [4:0]       index_out_q;
	logic [7:0]       byte_out_q;
	logic             last_q;

	logic             accept;
	logic             acc_byte;
	logic             acc_table;
	logic [7:0]       tbl_rdata;
	logic [7:0]       len_found;
	logic [7:0]       pay_rdata;
	logic             pay_we;
	logic [LEN_W-1:0] fill_next;
	logic [LEN_W-1:0] rd_next;
	logic             out_free;
	logic             res_last;
	logic             crc_match;

	sfr_pkg::crc_cmd_t crc_cmd;
	sfr_pkg::crc_sts_t crc_sts;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign acc_byte  = accept && (operation == sfr_pkg::OP_BYTE);
	assign acc_table = accept && (operation == sfr_pkg::OP_TABLE);

	assign crc_cmd.start = acc_byte && ((phase_q == PH_VERSION) || (phase_q == PH_TYPE) ||
	                                    (phase_q == PH_PAYLOAD));
	assign crc_cmd.init  = (phase_q == PH_VERSION);
	assign crc_cmd.data  = rx_byte;

	sfr_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (crc_cmd),
		.sts    (crc_sts)
	);

	// length table, read address follows the line byte so the type lookup lands next cycle
	sfr_ram #(
		.WIDTH (8),
		.DEPTH (sfr_pkg::TABLE_DEPTH)
	) u_len_tbl (
		.clk   (clk),
		.we    (acc_table),
		.waddr (table_type),
		.wdata (table_length),
		.raddr (rx_byte),
		.rdata (tbl_rdata)
	);

	assign pay_we = acc_byte && (phase_q == PH_PAYLOAD);

	sfr_ram #(
		.WIDTH (8),
		.DEPTH (MAX_PAYLOAD)
	) u_pay_store (
		.clk   (clk),
		.we    (pay_we),
		.waddr (fill_q[AW-1:0]),
		.wdata (rx_byte),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (pay_rdata)
	);

	// entries never written read as zero
	assign len_found = tvalid_q[type_q] ? tbl_rdata : 8'h00;
	assign fill_next = fill_q + LEN_W'(1);
	assign rd_next   = rd_idx_q + LEN_W'(1);
	assign out_free  = !out_valid_q || out_ready;
	assign res_last  = single_q || (rd_next == exp_len_q);
	assign crc_match = (crc_sts.crc == {rx_byte, crc_lo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_SYNC;
			sync_q    <= sfr_pkg::SYNC_RESET;
			version_q <= '0;
			type_q    <= '0;
			exp_len_q <= '0;
			fill_q    <= '0;
			rd_idx_q  <= '0;
			crc_lo_q  <= '0;
			lookup_q  <= 1'b0;
			single_q  <= 1'b0;
			err_q     <= 1'b0;
			tvalid_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				sync_q <= cfg_data;
			end
			if (acc_table) begin
				tvalid_q[table_type] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (acc_byte) begin
						case (phase_q)
							PH_SYNC: begin
								if (rx_byte == sync_q) begin
									phase_q <= PH_VERSION;
								end
							end
							PH_VERSION: begin
								version_q <= rx_byte;
								phase_q   <= PH_TYPE;
								state_q   <= S_CRC;
							end
							PH_TYPE: begin
								type_q   <= rx_byte;
								fill_q   <= '0;
								lookup_q <= 1'b1;
								state_q  <= S_CRC;
							end
							PH_PAYLOAD: begin
								fill_q  <= fill_next;
								state_q <= S_CRC;
								if (fill_next >= exp_len_q) begin
									phase_q <= PH_CRC_LO;
								end
							end
							PH_CRC_LO: begin
								crc_lo_q <= rx_byte;
								phase_q  <= PH_CRC_HI;
							end
							PH_CRC_HI: begin
								phase_q  <= PH_SYNC;
								err_q    <= !crc_match;
								single_q <= !crc_match || (exp_len_q == '0);
								rd_idx_q <= '0;
								state_q  <= S_RD;
							end
							default: begin
								phase_q <= PH_SYNC;
							end
						endcase
					end
				end
				S_CRC: begin
					if (lookup_q) begin
						lookup_q <= 1'b0;
						if (len_found > 8'(MAX_PAYLOAD)) begin
							phase_q <= PH_SYNC;
						end else begin
							exp_len_q <= LEN_W'(len_found);
							phase_q   <= (len_found == 8'h00) ? PH_CRC_LO : PH_PAYLOAD;
						end
					end
					if (!crc_sts.busy) begin
						state_q <= S_IDLE;
					end
				end
				S_RD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						if (res_last) begin
							state_q <= S_IDLE;
						end else begin
							rd_idx_q <= rd_next;
							state_q  <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			status_q      <= err_q ? sfr_pkg::ST_BAD : sfr_pkg::ST_GOOD;
			version_out_q <= version_q;
			type_out_q    <= type_q;
			length_out_q  <= 6'(exp_len_q);
			index_out_q   <= single_q ? 5'd0 : 5'(rd_idx_q);
			byte_out_q    <= single_q ? 8'h00 : pay_rdata;
			last_q        <= res_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign frame_ver     = version_out_q;
	assign frame_type    = type_out_q;
	assign frame_length  = length_out_q;
	assign byte_index    = index_out_q;
	assign payload_byte  = byte_out_q;
	assign last          = last_q;

endmodule

FILE: hdl/sfr_checker.sv
// port-level checks for the frame receiver, bound to the top level
module sfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       status,
	input logic [4:0] byte_index,
	input logic [7:0] payload_byte,
	input logic       last
);

	// a pending word is held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_index) &&
		$stable(payload_byte) && $stable(last) && $stable(status))
	else $error("result word changed while stalled");

	// a bad frame gives a single empty word
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == sfr_pkg::ST_BAD) |->
		last && (byte_index == 5'd0) && (payload_byte == 8'h00))
	else $error("error word is not a single empty word");

	// while a frame is still draining no line byte is taken
	a_drain_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
	else $error("input taken while frame still draining");

endmodule

bind sync_type_crc16_frame_receiver_unit sfr_checker u_sfr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.byte_index   (byte_index),
	.payload_byte (payload_byte),
	.last         (last)
);
